// ===== hw/rtl/swm_pkg.sv =====
// Shared constants and types for the sliding window median filter.
// Depends on nothing; every other file imports it.
package swm_pkg;

  localparam int SWM_WINDOW = 50;
  localparam int PIXEL_W    = 8;

  typedef logic [PIXEL_W-1:0] pixel_t;

  // Values broadcast from the top level to every cell for one item.
  typedef struct packed {
    logic   load;    // an item is accepted in this cycle
    logic   full;    // the window is full, so the oldest value leaves
    pixel_t pixel;   // the new pixel
    pixel_t oldest;  // the pixel that leaves the window when it is full
  } cell_ctrl_t;

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    pixel_t rest;    // its entry after the oldest value is removed
    logic   le;      // that entry is valid and not above the new pixel
  } cell_link_t;

endpackage

// ===== hw/rtl/swm_if.sv =====
// Valid/ready channels of the sliding window median filter.
// Depends on swm_pkg for the pixel type.
interface swm_pixel_if
  import swm_pkg::*;
  ();
  logic   valid;
  logic   ready;
  pixel_t pixel;
  logic   row_start;

  modport source (output valid, output pixel, output row_start, input ready);
  modport sink   (input valid, input pixel, input row_start, output ready);
endinterface

interface swm_median_if
  import swm_pkg::*;
  ();
  logic   valid;
  logic   ready;
  pixel_t median_value;

  modport source (output valid, output median_value, input ready);
  modport sink   (input valid, input median_value, output ready);
endinterface

// ===== hw/rtl/swm_cell.sv =====
// One cell of the sorted window: a sorted entry and an arrival-history tap.
// Depends on swm_pkg for the broadcast and link types.
module swm_cell
  import swm_pkg::*;
  (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       in_range,     // this entry takes part in the insert
  input  pixel_t     right_value,  // sorted entry of the right-hand neighbor
  input  pixel_t     right_hist,   // history tap of the right-hand neighbor
  input  cell_link_t left,         // link from the left-hand neighbor
  output cell_link_t link,
  output pixel_t     hist,
  output pixel_t     value,
  output pixel_t     value_next
);

  logic   removed;

  // Sorted order puts the first copy of the oldest value at the first entry
  // not below it, so every entry from there on moves one place left.
  always_comb begin
    removed    = ctrl.full && (value >= ctrl.oldest);
    link.rest  = removed ? right_value : value;
    link.le    = in_range && (link.rest <= ctrl.pixel);
    if (link.le) begin
      value_next = link.rest;
    end else if (left.le) begin
      value_next = ctrl.pixel;
    end else begin
      value_next = left.rest;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= value_next;
      hist  <= right_hist;
    end
  end

endmodule

// ===== hw/rtl/sliding_window_median.sv =====
// Top level of the sliding window median filter: a chain of swm_cell.
// Depends on swm_pkg, swm_if.sv and swm_cell.sv.
//
//   channel  | modport | payload             | role
//   ---------+---------+---------------------+--------------------------------
//   pixels   | sink    | pixel, row_start    | gray pixels of a row, in order
//   medians  | source  | median_value        | upper median of the last WINDOW
//
// Every cell updates its sorted entry in parallel from its own value, its
// neighbors and the broadcast pixel, so a new pixel can be accepted in every
// cycle while the output is not stalled. A median shows on the output register
// in the cycle after the pixel that completes it. Reset (synchronous,
// active high) empties the window and clears the output valid. When a median
// waits unread, no new pixel is accepted, since that pixel could produce
// another median; pixels.ready is low exactly while the output is stalled.
module sliding_window_median
  import swm_pkg::*;
  #(
  parameter int WINDOW = SWM_WINDOW
) (
  input logic          clk,
  input logic          rst,
  swm_pixel_if.sink    pixels,
  swm_median_if.source medians
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

  // Number of pixels of the current row held in the window, up to WINDOW.
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  logic [CNT_W-1:0] count_eff;

  logic       accept;
  logic       produce;
  cell_ctrl_t ctrl;

  pixel_t     hist   [WINDOW];
  pixel_t     nxt    [WINDOW];
  cell_link_t link   [WINDOW];
  pixel_t     values [WINDOW];

  assign pixels.ready = !medians.valid || medians.ready;
  assign accept       = pixels.valid && pixels.ready;

  // A row start empties the window before the new pixel goes in.
  assign count_eff = pixels.row_start ? '0 : fill_count;
  assign produce   = count_eff >= CNT_LAST;

  always_comb begin
    ctrl.load   = accept;
    ctrl.full   = (count_eff == CNT_FULL);
    ctrl.pixel  = pixels.pixel;
    ctrl.oldest = hist[0];
    fill_count_next = (count_eff == CNT_FULL) ? CNT_FULL : count_eff + 1'b1;
  end

  // The history shifts toward cell 0 with every pixel; after WINDOW pixels
  // of a row the oldest one sits in cell 0.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic       in_range;
    pixel_t     right_value;
    pixel_t     right_hist;
    cell_link_t left;

    // When full, the removal leaves WINDOW-1 entries; while filling, only
    // the first count_eff entries hold pixels of this row.
    assign in_range = ctrl.full ? (IDX < CNT_LAST) : (IDX < count_eff);

    if (i == WINDOW - 1) begin : g_last
      assign right_value = '0;
      assign right_hist  = pixels.pixel;
    end else begin : g_inner
      assign right_value = values[i+1];
      assign right_hist  = hist[i+1];
    end

    if (i == 0) begin : g_first
      // The new pixel goes to the front when nothing precedes it.
      assign left.rest = '0;
      assign left.le   = 1'b1;
    end else begin : g_follow
      assign left = link[i-1];
    end

    swm_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .in_range   (in_range),
      .right_value(right_value),
      .right_hist (right_hist),
      .left       (left),
      .link       (link[i]),
      .hist       (hist[i]),
      .value      (values[i]),
      .value_next (nxt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      medians.valid <= 1'b0;
    end else begin
      if (accept) begin
        fill_count <= fill_count_next;
      end
      if (accept) begin
        medians.valid <= produce;
      end else if (medians.ready) begin
        medians.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      medians.median_value <= nxt[WINDOW/2];
    end
  end

endmodule
